@@ rtl/mafl_pkg.sv @@
// Shared definitions for the MAC address filter table.
// Command and status codes, register indexes, default sizes and the bucket hash.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mafl_pkg;

  localparam int ADDR_W      = 48;
  localparam int HASH_W      = 10;
  localparam int REG_IDX_W   = 1;
  localparam int REG_DATA_W  = 1;
  localparam int BUCKETS_DEF = 64;
  localparam int WAYS_DEF    = 4;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_DEL   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_CHECK = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_PRESENT = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  localparam logic [REG_IDX_W-1:0] REG_FILTER_ENABLE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIST_MODE     = 1'd1;

  // Sum of the three XORed octet pairs (first with last, and so on inward)
  function automatic logic [HASH_W-1:0] hash_sum(input logic [ADDR_W-1:0] a);
    logic [HASH_W-1:0] p0;
    logic [HASH_W-1:0] p1;
    logic [HASH_W-1:0] p2;
    p0 = {2'b00, a[47:40] ^ a[7:0]};
    p1 = {2'b00, a[39:32] ^ a[15:8]};
    p2 = {2'b00, a[31:24] ^ a[23:16]};
    return p0 + p1 + p2;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mafl_ifs.sv @@
// Request and result channel interfaces of the MAC address filter table.
// Valid/ready handshake; address widths come from mafl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mafl_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [mafl_pkg::ADDR_W-1:0] first_addr;
  logic [mafl_pkg::ADDR_W-1:0] second_addr;

  modport source (output valid, output command, output first_addr, output second_addr,
                  input ready);
  modport sink   (input valid, input command, input first_addr, input second_addr,
                  output ready);
endinterface

interface mafl_rsp_if;
  logic       valid;
  logic       ready;
  logic       accept;
  logic [2:0] status;

  modport source (output valid, output accept, output status, input ready);
  modport sink   (input valid, input accept, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/mafl_addr_ram.sv @@
// Address store of the filter table: one row per bucket, one 48-bit word per way.
// Two registered read ports, one write port with way select. Uses mafl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mafl_addr_ram #(
  parameter int ROWS  = mafl_pkg::BUCKETS_DEF,
  parameter int WAYS  = mafl_pkg::WAYS_DEF,
  parameter int ROW_W = 6,
  parameter int WAY_W = 2
) (
  input  wire logic                                 clk,
  input  wire logic                                 rd_en,
  input  wire logic [ROW_W-1:0]                     rd_row_a,
  input  wire logic [ROW_W-1:0]                     rd_row_b,
  output      logic [WAYS-1:0][mafl_pkg::ADDR_W-1:0] rd_data_a,
  output      logic [WAYS-1:0][mafl_pkg::ADDR_W-1:0] rd_data_b,
  input  wire logic                                 wr_en,
  input  wire logic [ROW_W-1:0]                     wr_row,
  input  wire logic [WAY_W-1:0]                     wr_way,
  input  wire logic [mafl_pkg::ADDR_W-1:0]          wr_addr
);
  import mafl_pkg::*;

  logic [WAYS-1:0][ADDR_W-1:0] mem [ROWS];

  // Single-way write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_way] <= wr_addr;
    end
  end

  // Two read ports, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_row_a];
      rd_data_b <= mem[rd_row_b];
    end
  end

endmodule

`default_nettype wire

@@ rtl/mac_address_filter_table.sv @@
// Top level of the MAC address filter table: hashed buckets of WAYS entries each.
// Uses mafl_pkg, mafl_ifs (mafl_req_if, mafl_rsp_if) and mafl_addr_ram.
//
//   channel   dir  payload                               accepted when
//   req       in   command, first_addr, second_addr      req.valid && req.ready
//   rsp       out  accept, status                        rsp.valid && rsp.ready
//   config    in   reg_index, reg_data                   write_en
//
// One request per cycle unless rsp stalls back up the pipe. A result passes the
// input register, then the registered RAM bucket reads, into the output register.
// Each request is decided in one pass against both read ports of the RAM.
// Sync rst resets all valid bits and control flags at once; no clearing pass.
// A stalled result holds the pipe only as far back as needed; bubbles still fill.
`timescale 1ns / 1ps
`default_nettype none

module mac_address_filter_table #(
  parameter int BUCKETS = mafl_pkg::BUCKETS_DEF,
  parameter int WAYS    = mafl_pkg::WAYS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  mafl_req_if.sink                            req,
  mafl_rsp_if.source                          rsp,
  input  wire logic                           write_en,
  input  wire logic [mafl_pkg::REG_IDX_W-1:0]  reg_index,
  input  wire logic [mafl_pkg::REG_DATA_W-1:0] reg_data
);
  import mafl_pkg::*;

  localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RECIP_SH = 2 * HASH_W;
  localparam int PROD_W   = RECIP_SH + HASH_W + 1;
  localparam longint RECIP = (64'd1 << RECIP_SH) / BUCKETS;

  typedef logic [WAYS-1:0][ADDR_W-1:0] row_data_t;

  // Hash sum modulo BUCKETS: reciprocal estimate, then one correction step
  function automatic logic [BKT_W-1:0] bucket_of(input logic [HASH_W-1:0] s);
    logic [PROD_W-1:0]   prod;
    logic [HASH_W-1:0]   q;
    logic [2*HASH_W+1:0] qb;
    logic [HASH_W:0]     r;
    prod = PROD_W'(s) * PROD_W'(RECIP);
    q    = prod[RECIP_SH +: HASH_W];
    qb   = (2*HASH_W+2)'(q) * (2*HASH_W+2)'(BUCKETS);
    r    = {1'b0, s} - qb[HASH_W:0];
    if (r >= (HASH_W+1)'(BUCKETS)) begin
      r = r - (HASH_W+1)'(BUCKETS);
    end
    return r[BKT_W-1:0];
  endfunction

  // Configuration registers
  logic filter_enable;
  logic list_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b1;
      list_mode     <= 1'b0;
    end else if (write_en) begin
      case (reg_index)
        REG_FILTER_ENABLE: filter_enable <= reg_data[0];
        REG_LIST_MODE:     list_mode     <= reg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic out_v, s1_v, s2_v;
  logic out_free, s2_go, s2_en, s1_en;

  assign out_free  = !out_v || rsp.ready;
  assign s2_go     = s2_v && out_free;
  assign s2_en     = !s2_v || out_free;
  assign s1_en     = !s1_v || s2_en;
  assign req.ready = s1_en;

  // Input register
  cmd_t              s1_cmd;
  logic [ADDR_W-1:0] s1_a, s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_en) begin
      s1_v <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_cmd <= cmd_t'(req.command);
      s1_a   <= req.first_addr;
      s1_b   <= req.second_addr;
    end
  end

  logic [BKT_W-1:0] s1_row_a, s1_row_b;
  assign s1_row_a = bucket_of(hash_sum(s1_a));
  assign s1_row_b = bucket_of(hash_sum(s1_b));

  // Decision stage registers
  cmd_t              s2_cmd;
  logic [ADDR_W-1:0] s2_a, s2_b;
  logic [BKT_W-1:0]  s2_row_a, s2_row_b;
  logic              byp_a, byp_b;
  logic [WAY_W-1:0]  byp_way;
  logic [ADDR_W-1:0] byp_addr;

  // Write port driven by the decision stage
  logic             wr_en;
  logic [WAY_W-1:0] free_way;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_en) begin
      s2_v <= s1_v;
    end
  end

  // Bypass: a write landing in the row being read this edge overrides that way
  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_cmd   <= s1_cmd;
      s2_a     <= s1_a;
      s2_b     <= s1_b;
      s2_row_a <= s1_row_a;
      s2_row_b <= s1_row_b;
      byp_a    <= wr_en && (s1_row_a == s2_row_a);
      byp_b    <= wr_en && (s1_row_b == s2_row_a);
      byp_way  <= free_way;
      byp_addr <= s2_a;
    end
  end

  row_data_t ram_a, ram_b;

  mafl_addr_ram #(
    .ROWS  (BUCKETS),
    .WAYS  (WAYS),
    .ROW_W (BKT_W),
    .WAY_W (WAY_W)
  ) u_ram (
    .clk       (clk),
    .rd_en     (s2_en),
    .rd_row_a  (s1_row_a),
    .rd_row_b  (s1_row_b),
    .rd_data_a (ram_a),
    .rd_data_b (ram_b),
    .wr_en     (wr_en),
    .wr_row    (s2_row_a),
    .wr_way    (free_way),
    .wr_addr   (s2_a)
  );

  // Valid bits, one per entry
  logic [WAYS-1:0] valid [BUCKETS];

  // Bucket compare for both addresses
  row_data_t       data_a, data_b;
  logic [WAYS-1:0] va, vb, match_a, match_b;
  logic            hit_a, hit_b, row_full;

  always_comb begin
    data_a = ram_a;
    data_b = ram_b;
    if (byp_a) begin
      data_a[byp_way] = byp_addr;
    end
    if (byp_b) begin
      data_b[byp_way] = byp_addr;
    end
    va = valid[s2_row_a];
    vb = valid[s2_row_b];
    for (int w = 0; w < WAYS; w++) begin
      match_a[w] = va[w] && (data_a[w] == s2_a);
      match_b[w] = vb[w] && (data_b[w] == s2_b);
    end
    hit_a    = |match_a;
    hit_b    = |match_b;
    row_full = &va;
  end

  // Lowest free way of the first address's bucket
  always_comb begin
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!va[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  // Verdict
  logic    addr_bad;
  logic    accept_next;
  status_t status_next;

  assign addr_bad = (s2_a == '0) || s2_a[40];

  always_comb begin
    accept_next = 1'b1;
    status_next = ST_OK;
    wr_en       = 1'b0;
    case (s2_cmd)
      CMD_ADD: begin
        if (addr_bad) begin
          status_next = ST_INVALID;
        end else if (hit_a) begin
          status_next = ST_PRESENT;
        end else if (row_full) begin
          status_next = ST_FULL;
        end else begin
          wr_en = s2_go;
        end
      end
      CMD_DEL: begin
        if (!hit_a) begin
          status_next = ST_ABSENT;
        end
      end
      CMD_CHECK: begin
        if (filter_enable) begin
          accept_next = (hit_a || hit_b) ? list_mode : !list_mode;
        end
      end
      default: ;
    endcase
  end

  // Valid bit updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUCKETS; i++) begin
        valid[i] <= '0;
      end
    end else if (s2_go) begin
      case (s2_cmd)
        CMD_CLEAR: begin
          for (int i = 0; i < BUCKETS; i++) begin
            valid[i] <= '0;
          end
        end
        CMD_ADD: begin
          if (wr_en) begin
            valid[s2_row_a][free_way] <= 1'b1;
          end
        end
        CMD_DEL: begin
          valid[s2_row_a] <= va & ~match_a;
        end
        default: ;
      endcase
    end
  end

  // Output register
  logic    out_accept;
  status_t out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_free) begin
      out_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_accept <= accept_next;
      out_status <= status_next;
    end
  end

  assign rsp.valid  = out_v;
  assign rsp.accept = out_accept;
  assign rsp.status = out_status;

  // Checks
  a_drop_only_on_check: assert property (@(posedge clk) disable iff (rst)
    (out_v && !out_accept) |-> (out_status == ST_OK))
    else $error("drop verdict with non-ok status");

  a_unfiltered_accepts: assert property (@(posedge clk) disable iff (rst)
    (s2_go && !filter_enable) |=> out_accept)
    else $error("frame dropped with filtering off");

  a_no_dup_a: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> $onehot0(match_a))
    else $error("duplicate address in bucket");

  a_no_dup_b: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> $onehot0(match_b))
    else $error("duplicate address in destination bucket");

  a_write_has_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (!row_full && !hit_a && !addr_bad))
    else $error("write into full bucket or of a rejected address");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for mac_address_filter_table: directed and random requests,
// with a small in-package scoreboard that predicts every result.
// Depends on rtl/mafl_pkg.sv, rtl/mafl_ifs.sv and rtl/mac_address_filter_table.sv.
`timescale 1ns / 1ps

package tb_filter_pkg;
  import mafl_pkg::*;

  localparam int TB_BUCKETS  = 64;
  localparam int TB_WAYS     = 4;
  localparam int TB_ENTRIES  = TB_BUCKETS * TB_WAYS;

  typedef struct packed {
    logic    accept;
    status_t status;
  } verdict_t;

  // Mirror of the table plus the queue of verdicts still owed by the block
  class mac_table_scoreboard;
    bit          filter_on;
    bit          allow_list;
    bit          slot_used [TB_ENTRIES];
    logic [47:0] slot_addr [TB_ENTRIES];
    verdict_t    verdicts_due[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned drops;
    int unsigned status_tally [5];

    function new();
      filter_on    = 1'b1;
      allow_list   = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      drops        = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      foreach (slot_addr[i]) slot_addr[i] = '0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] data);
      if (idx == REG_FILTER_ENABLE) filter_on = data[0];
      else if (idx == REG_LIST_MODE) allow_list = data[0];
    endfunction

    // Bucket: sum of the three XORed octet pairs, modulo the bucket count
    function int unsigned bucket_of(logic [47:0] a);
      int unsigned s;
      s = int'(a[47:40] ^ a[7:0]) + int'(a[39:32] ^ a[15:8]) + int'(a[31:24] ^ a[23:16]);
      return s % TB_BUCKETS;
    endfunction

    // Slot holding address a, or -1
    function int lookup(logic [47:0] a);
      int base;
      base = bucket_of(a) * TB_WAYS;
      for (int w = 0; w < TB_WAYS; w++) begin
        if (slot_used[base + w] && slot_addr[base + w] == a) return base + w;
      end
      return -1;
    endfunction

    // Apply one accepted request to the mirror and queue the verdict it owes
    function void note_request(cmd_t cmd, logic [47:0] a, logic [47:0] b);
      verdict_t v;
      int       slot;
      int       base;
      bit       hit;
      bit       placed;
      v.accept = 1'b1;
      v.status = ST_OK;
      case (cmd)
        CMD_ADD: begin
          if (a == '0 || a[40]) begin
            v.status = ST_INVALID;
          end else if (lookup(a) >= 0) begin
            v.status = ST_PRESENT;
          end else begin
            base   = bucket_of(a) * TB_WAYS;
            placed = 1'b0;
            for (int w = 0; w < TB_WAYS; w++) begin
              if (!placed && !slot_used[base + w]) begin
                slot_used[base + w] = 1'b1;
                slot_addr[base + w] = a;
                placed = 1'b1;
              end
            end
            v.status = placed ? ST_OK : ST_FULL;
          end
        end
        CMD_DEL: begin
          slot = lookup(a);
          if (slot < 0) v.status = ST_ABSENT;
          else slot_used[slot] = 1'b0;
        end
        CMD_CLEAR: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
        end
        default: begin
          if (filter_on) begin
            hit = (lookup(a) >= 0) || (lookup(b) >= 0);
            v.accept = allow_list ? hit : !hit;
          end
        end
      endcase
      if (!v.accept) drops++;
      status_tally[v.status]++;
      verdicts_due.push_back(v);
    endfunction

    // Compare one result from the block with the oldest verdict due
    function void check_result(logic accept, logic [2:0] status);
      verdict_t v;
      results_seen++;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual accept %0b status %0d",
                 $time, accept, status);
        return;
      end
      v = verdicts_due.pop_front();
      if (accept !== v.accept) begin
        mismatches++;
        $display("%0t: accept mismatch: expected %0b, actual %0b", $time, v.accept, accept);
      end
      if (status !== v.status) begin
        mismatches++;
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, v.status, status);
      end
    endfunction
  endclass

endpackage

module tb_top;
  import mafl_pkg::*;
  import tb_filter_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 270;
  localparam int POOL_SIZE   = 32;

  logic                  clk;
  logic                  rst;
  logic                  write_en;
  logic [REG_IDX_W-1:0]  reg_index;
  logic [REG_DATA_W-1:0] reg_data;

  mafl_req_if req_if ();
  mafl_rsp_if rsp_if ();

  mac_table_scoreboard board;
  bit                  no_idle;
  logic [47:0]         addr_pool [POOL_SIZE];
  int unsigned         settings_run;

  mac_address_filter_table #(
    .BUCKETS (TB_BUCKETS),
    .WAYS    (TB_WAYS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .write_en  (write_en),
    .reg_index (reg_index),
    .reg_data  (reg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls on ready
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        stall--;
      end else begin
        rsp_if.ready = 1'b1;
        if ($urandom_range(0, 99) < 20) stall = pick_gap();
      end
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      board.check_result(rsp_if.accept, rsp_if.status);
  end

  // One request: optional gap, then hold until accepted. Entered and left at a falling edge.
  task automatic send_request(input cmd_t cmd, input logic [47:0] a, input logic [47:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       = 1'b1;
    req_if.command     = cmd;
    req_if.first_addr  = a;
    req_if.second_addr = b;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    board.note_request(cmd, a, b);
    @(negedge clk);
  endtask

  // Wait until every owed result is back, then a short pause for the pipe
  task automatic settle();
    req_if.valid = 1'b0;
    while (board.verdicts_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [REG_DATA_W-1:0] data);
    write_en  = 1'b1;
    reg_index = idx;
    reg_data  = data;
    @(negedge clk);
    write_en = 1'b0;
    board.set_register(idx, data);
  endtask

  // Addresses that all land in bucket 2: {02, x, 00, 00, x, 00}
  function automatic logic [47:0] bucket2_addr(input logic [7:0] x);
    return {8'h02, x, 8'h00, 8'h00, x, 8'h00};
  endfunction

  function automatic logic [47:0] random_addr();
    logic [31:0] lo;
    logic [15:0] hi;
    lo = $urandom;
    hi = 16'($urandom);
    return {hi, lo};
  endfunction

  // Pool: most addresses crowd four hot buckets so that buckets fill up
  task automatic refill_pool();
    logic [7:0] hot [4];
    logic [7:0] o0, o1, o2;
    foreach (hot[k]) hot[k] = 8'($urandom_range(0, TB_BUCKETS - 1));
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < 24) begin
        o0 = 8'($urandom) & 8'hFE;
        o1 = 8'($urandom);
        o2 = 8'($urandom);
        addr_pool[i] = {o0, o1, o2, o2, o1, o0 ^ hot[i % 4]};
      end else begin
        addr_pool[i] = random_addr();
        addr_pool[i][40] = 1'b0;
        addr_pool[i][1] = 1'b1;
      end
    end
  endtask

  function automatic logic [47:0] pick_addr();
    int unsigned r;
    logic [47:0] a;
    r = $urandom_range(0, 99);
    if (r < 65) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 80) return random_addr();
    if (r < 88) begin
      a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      a[40] = 1'b1;
      return a;
    end
    if (r < 92) return '0;
    if (r < 96) return '1;
    a = random_addr();
    a[40] = 1'b0;
    return a;
  endfunction

  task automatic random_requests(input int unsigned count);
    int unsigned r;
    cmd_t        cmd;
    for (int unsigned i = 0; i < count; i++) begin
      // occasional stretches with no idling on either side
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 199);
      if (r < 76) cmd = CMD_ADD;
      else if (r < 116) cmd = CMD_DEL;
      else if (r < 197) cmd = CMD_CHECK;
      else cmd = CMD_CLEAR;
      send_request(cmd, pick_addr(), pick_addr());
    end
    no_idle = 1'b0;
  endtask

  // Directed cases, first under the reset register values
  task automatic run_directed();
    logic [47:0] stranger;
    stranger = 48'h0a1b2c3d4e5f;
    send_request(CMD_CHECK, '1, '1);
    // invalid adds: zero, broadcast, multicast
    send_request(CMD_ADD, '0, '0);
    send_request(CMD_ADD, '1, '0);
    send_request(CMD_ADD, 48'h01005e000001, '0);
    // fill bucket 2, then overflow it
    for (int x = 0; x < 5; x++) send_request(CMD_ADD, bucket2_addr(8'(x)), '0);
    send_request(CMD_ADD, bucket2_addr(1), '0);
    // block list: hit on source, then on destination
    send_request(CMD_CHECK, bucket2_addr(1), stranger);
    send_request(CMD_CHECK, stranger, bucket2_addr(2));
    // deletes: absent, zero, present, then again
    send_request(CMD_DEL, stranger, '1);
    send_request(CMD_DEL, '0, '0);
    send_request(CMD_DEL, bucket2_addr(1), '0);
    send_request(CMD_DEL, bucket2_addr(1), '0);
    // freed way is reused, then bucket is full again
    send_request(CMD_ADD, bucket2_addr(4), '0);
    send_request(CMD_ADD, bucket2_addr(5), '0);
    // largest unicast address; second operand ignored
    send_request(CMD_ADD, 48'hfeffffffffff, '1);
    send_request(CMD_CLEAR, '1, '1);
    send_request(CMD_CHECK, bucket2_addr(2), stranger);
    send_request(CMD_ADD, bucket2_addr(2), '0);
    // allow list
    settle();
    write_register(REG_LIST_MODE, 1'b1);
    send_request(CMD_CHECK, stranger, bucket2_addr(2));
    send_request(CMD_CHECK, stranger, stranger);
    // filtering off
    settle();
    write_register(REG_FILTER_ENABLE, 1'b0);
    send_request(CMD_CHECK, stranger, stranger);
    send_request(CMD_CHECK, bucket2_addr(2), bucket2_addr(2));
    settings_run = 3;
  endtask

  // Main sequence
  initial begin : stimulus
    bit phase_enable [PHASES];
    bit phase_allow  [PHASES];
    phase_enable = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    phase_allow  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    rst                = 1'b1;
    write_en           = 1'b0;
    reg_index          = REG_FILTER_ENABLE;
    reg_data           = '0;
    req_if.valid       = 1'b0;
    req_if.command     = CMD_ADD;
    req_if.first_addr  = '0;
    req_if.second_addr = '0;
    no_idle            = 1'b0;
    settings_run       = 0;
    board              = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_register(REG_FILTER_ENABLE, phase_enable[p]);
      write_register(REG_LIST_MODE, phase_allow[p]);
      settings_run++;
      refill_pool();
      random_requests(PHASE_ITEMS);
    end

    settle();
    repeat (8) @(negedge clk);

    $display("Checked %0d results over %0d register settings; %0d frames dropped.",
             board.results_seen, settings_run, board.drops);
    $display("Status counts: ok %0d, invalid %0d, present %0d, absent %0d, full %0d.",
             board.status_tally[ST_OK], board.status_tally[ST_INVALID],
             board.status_tally[ST_PRESENT], board.status_tally[ST_ABSENT],
             board.status_tally[ST_FULL]);
    if (board.mismatches == 0 && board.verdicts_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
